// File: design/acire_pkg.sv
// shared types, constants and code tables of the ir remote frame encoder
package acire_pkg;

  localparam int FRAME_BYTES_DEF   = 9;
  localparam int FRAME_REPEATS_DEF = 2;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  // register indexes of the configuration port
  typedef enum logic [CFG_AW-1:0] {
    REG_LEAD_MARK  = 3'd0,
    REG_LEAD_SPACE = 3'd1,
    REG_PULSE_MARK = 3'd2,
    REG_SPACE_ONE  = 3'd3,
    REG_SPACE_ZERO = 3'd4,
    REG_GAP_SPACE  = 3'd5,
    REG_TEMP_FLOOR = 3'd6,
    REG_TEMP_CEIL  = 3'd7
  } reg_idx_t;

  localparam logic [15:0] LEAD_MARK_RST  = 16'd4400;
  localparam logic [15:0] LEAD_SPACE_RST = 16'd4300;
  localparam logic [15:0] PULSE_MARK_RST = 16'd580;
  localparam logic [15:0] SPACE_ONE_RST  = 16'd1600;
  localparam logic [15:0] SPACE_ZERO_RST = 16'd490;
  localparam logic [15:0] GAP_SPACE_RST  = 16'd7400;
  localparam logic [7:0]  TEMP_FLOOR_RST = 8'd17;
  localparam logic [7:0]  TEMP_CEIL_RST  = 8'd30;

  // fixed frame bytes
  localparam logic [7:0] FRAME_ID     = 8'hF2;
  localparam logic [7:0] MODEL_BASE   = 8'h03;
  localparam logic [7:0] FRAME_CONST4 = 8'h01;
  localparam logic [2:0] MODE_MAX     = 3'd5;
  localparam logic [2:0] MODE_COOL    = 3'd1;
  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] FAN_MAX      = 3'd3;
  localparam logic [2:0] SWING_ON_CODE  = 3'd1;
  localparam logic [2:0] SWING_OFF_CODE = 3'd2;
  localparam logic [2:0] VANE_TOGGLE_CODE = 3'd4;
  localparam logic [2:0] VANE_STEP_CODE   = 3'd0;
  localparam logic [1:0] TOGGLE_BTN_MAX = 2'd2;
  localparam logic [1:0] EXTRA_BTN_MAX  = 2'd1;
  localparam logic [1:0] BTN_POWER_OFF  = 2'd0;

  localparam logic OP_SUBMIT  = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    KIND_STATE  = 2'd0,
    KIND_TOGGLE = 2'd1,
    KIND_EXTRA  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DURATION = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_REJECTED = 2'd2,
    ST_IDLE     = 2'd3
  } status_t;

  typedef struct packed {
    logic       op;
    logic [1:0] kind;
    logic [2:0] mode_sel;
    logic [2:0] fan_sel;
    logic [7:0] setpoint;
    logic [3:0] model_sel;
    logic       swing_on;
    logic       filter_on;
    logic [1:0] button;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        level;
    logic [15:0] duration_us;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] lead_mark;
    logic [15:0] lead_space;
    logic [15:0] pulse_mark;
    logic [15:0] space_one;
    logic [15:0] space_zero;
    logic [15:0] gap_space;
    logic [7:0]  temp_floor;
    logic [7:0]  temp_ceil;
  } enc_cfg_t;

  // mode code on the air, index already clamped to 0..5
  function automatic logic [2:0] mode_code(input logic [2:0] m);
    logic [2:0] c;
    unique case (m)
      3'd0:    c = 3'd7;
      3'd1:    c = 3'd1;
      3'd2:    c = 3'd0;
      3'd3:    c = 3'd2;
      3'd4:    c = 3'd3;
      3'd5:    c = 3'd4;
      default: c = 3'd7;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] fan_code(input logic [1:0] f);
    logic [2:0] c;
    unique case (f)
      2'd0:    c = 3'd0;
      2'd1:    c = 3'd1;
      2'd2:    c = 3'd3;
      default: c = 3'd5;
    endcase
    return c;
  endfunction

endpackage

// File: design/acire_in_if.sv
// input item channel
interface acire_in_if import acire_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/acire_out_if.sv
// result item channel
interface acire_out_if import acire_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/acire_frame_build.sv
// command check, field clamping and frame assembly with checksum
module acire_frame_build import acire_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  in_item_t               item,
  input  logic [7:0]             temp_floor,
  input  logic [7:0]             temp_ceil,
  output logic                   cmd_ok,
  output logic [0:FRAME_BYTES*8-1] frame
);

  logic       power;
  logic [2:0] swing;
  logic [2:0] mode;
  logic [1:0] fan;
  logic       model;
  logic [7:0] t_lo;
  logic [7:0] t_cl;
  logic [7:0] t_diff;
  logic [7:0] b [0:7];
  logic [7:0] chk;

  always_comb begin
    power  = 1'b1;
    swing  = item.swing_on ? SWING_ON_CODE : SWING_OFF_CODE;
    cmd_ok = 1'b0;
    unique case (kind_t'(item.kind))
      KIND_STATE: begin
        cmd_ok = (item.mode_sel != MODE_OFF) && (item.mode_sel <= MODE_MAX);
      end
      KIND_TOGGLE: begin
        cmd_ok = item.button <= TOGGLE_BTN_MAX;
        power  = item.button != BTN_POWER_OFF;
      end
      KIND_EXTRA: begin
        cmd_ok = item.button <= EXTRA_BTN_MAX;
        swing  = (item.button != 2'd0) ? VANE_TOGGLE_CODE : VANE_STEP_CODE;
      end
      default: cmd_ok = 1'b0;
    endcase

    mode = (item.mode_sel <= MODE_MAX) ? item.mode_sel : MODE_COOL;
    if (!power) mode = MODE_OFF;
    fan   = (item.fan_sel <= FAN_MAX) ? item.fan_sel[1:0] : 2'd0;
    model = (item.model_sel <= 4'd1) ? item.model_sel[0] : 1'b0;

    // floor first, then ceiling wins
    t_lo   = (item.setpoint < temp_floor) ? temp_floor : item.setpoint;
    t_cl   = (t_lo > temp_ceil) ? temp_ceil : t_lo;
    t_diff = t_cl - temp_floor;

    b[0] = FRAME_ID;
    b[1] = ~FRAME_ID;
    b[2] = MODEL_BASE | {3'd0, model, 4'd0};
    b[3] = ~b[2];
    b[4] = FRAME_CONST4;
    b[5] = {t_diff[3:0], 1'b0, swing};
    b[6] = {fan_code(fan), 2'd0, mode_code(mode)};
    b[7] = {3'd0, item.filter_on, 4'd0};

    chk = 8'd0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      frame[8*i +: 8] = b[i];
      chk ^= b[i];
    end
    frame[8*(FRAME_BYTES-1) +: 8] = chk;
  end

endmodule

// File: design/acire_seq.sv
// frame store and mark/space sequencer, one result per accepted item
module acire_seq import acire_pkg::*; #(
  parameter int FRAME_BYTES   = FRAME_BYTES_DEF,
  parameter int FRAME_REPEATS = FRAME_REPEATS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      take,
  input  in_item_t  item,
  input  enc_cfg_t  cfg,
  output out_item_t res
);

  localparam int NBITS     = FRAME_BYTES * 8;
  localparam int PASS_LEN  = 2 + 16 * FRAME_BYTES;
  localparam int BLOCK_LEN = PASS_LEN + 2;
  localparam int QW        = $clog2(BLOCK_LEN);
  localparam int RW        = (FRAME_REPEATS > 1) ? $clog2(FRAME_REPEATS) : 1;
  localparam int BW        = $clog2(NBITS);

  logic [0:NBITS-1] frame_r;
  logic [QW-1:0]    q_r;
  logic [RW-1:0]    rep_r;
  logic             sending_r;

  logic [0:NBITS-1] new_frame;
  logic             cmd_ok;
  logic [QW-1:0]    k;
  logic [BW-1:0]    bit_idx;
  logic             is_last;
  logic             blk_end;

  acire_frame_build #(.FRAME_BYTES(FRAME_BYTES)) u_build (
    .item       (item),
    .temp_floor (cfg.temp_floor),
    .temp_ceil  (cfg.temp_ceil),
    .cmd_ok     (cmd_ok),
    .frame      (new_frame)
  );

  assign k       = q_r - QW'(2);
  assign bit_idx = BW'(k >> 1);
  assign is_last = (rep_r == RW'(FRAME_REPEATS - 1)) && (q_r == QW'(PASS_LEN));
  assign blk_end = q_r == QW'(BLOCK_LEN - 1);

  always_comb begin
    res = '0;
    if (item.op == OP_SUBMIT) begin
      res.status = cmd_ok ? ST_ACCEPTED : ST_REJECTED;
    end else if (!sending_r) begin
      res.status = ST_IDLE;
    end else begin
      res.status = ST_DURATION;
      priority if (is_last) begin
        res.level       = 1'b1;
        res.duration_us = cfg.pulse_mark;
        res.last        = 1'b1;
      end else if (q_r == QW'(0)) begin
        res.level       = 1'b1;
        res.duration_us = cfg.lead_mark;
      end else if (q_r == QW'(1)) begin
        res.duration_us = cfg.lead_space;
      end else if (q_r < QW'(PASS_LEN)) begin
        if (!k[0]) begin
          res.level       = 1'b1;
          res.duration_us = cfg.pulse_mark;
        end else begin
          res.duration_us = frame_r[bit_idx] ? cfg.space_one : cfg.space_zero;
        end
      end else if (q_r == QW'(PASS_LEN)) begin
        res.level       = 1'b1;
        res.duration_us = cfg.pulse_mark;
      end else begin
        res.duration_us = cfg.gap_space;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r   <= '0;
      q_r       <= '0;
      rep_r     <= '0;
      sending_r <= 1'b0;
    end else if (take) begin
      if (item.op == OP_SUBMIT) begin
        if (cmd_ok) begin
          frame_r   <= new_frame;
          q_r       <= '0;
          rep_r     <= '0;
          sending_r <= 1'b1;
        end
      end else if (sending_r) begin
        if (is_last) begin
          sending_r <= 1'b0;
          q_r       <= '0;
          rep_r     <= '0;
        end else if (blk_end) begin
          q_r   <= '0;
          rep_r <= rep_r + RW'(1);
        end else begin
          q_r <= q_r + QW'(1);
        end
      end
    end
  end

endmodule

// File: design/acire_skid.sv
// two-entry result buffer: output register plus skid register
module acire_skid import acire_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  out_item_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output out_item_t pop_data
);

  logic      out_v_r;
  out_item_t out_d_r;
  logic      sk_v_r;
  out_item_t sk_d_r;
  logic      push;

  assign push_ready = !sk_v_r;
  assign push       = push_valid && !sk_v_r;
  assign pop_valid  = out_v_r;
  assign pop_data   = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (!out_v_r || pop_ready) begin
      if (sk_v_r) begin
        out_d_r <= sk_d_r;
        out_v_r <= 1'b1;
        sk_v_r  <= 1'b0;
      end else begin
        out_d_r <= push_data;
        out_v_r <= push;
      end
    end else if (push) begin
      sk_d_r <= push_data;
      sk_v_r <= 1'b1;
    end
  end

endmodule

// File: design/ac_ir_remote_frame_encoder.sv
// top level of the pulse-distance ir frame encoder for an air conditioner remote
//
// a submit item (op 0) checks and clamps a command and, if valid, latches a new
// frame of FRAME_BYTES bytes (fixed id bytes, model, swing/vane and temperature,
// mode and fan, filter bit, xor checksum) and restarts transmission; it returns
// status accepted or rejected. each advance item (op 1) returns the next mark or
// space: per copy a header mark and space, then a bit mark and a one/zero space
// per bit msb first, with a bit mark and repeat gap between copies and a final
// bit mark flagged last. advance while idle returns status nothing-pending.
// every item gives exactly one result. one item is accepted per clock cycle
// while the output buffer has room. the sequencer position counter and the
// frame register are updated in the same cycle the item is taken, so
// back-to-back advances need no bubbles. a two-entry output buffer keeps the
// input side taking items while one result waits on a stalled consumer; input
// ready drops only when both entries are full. the user must write timing
// registers through the cfg port only while no item is in flight; the block
// does not check this. there is no clearing pass after reset.
module ac_ir_remote_frame_encoder import acire_pkg::*; #(
  parameter int FRAME_BYTES   = FRAME_BYTES_DEF,
  parameter int FRAME_REPEATS = FRAME_REPEATS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  acire_in_if.sink          in_ch,
  acire_out_if.source       out_ch,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  enc_cfg_t  cfg_r;
  out_item_t res;
  logic      take;

  // configuration registers, 8-bit ones keep the low byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lead_mark  <= LEAD_MARK_RST;
      cfg_r.lead_space <= LEAD_SPACE_RST;
      cfg_r.pulse_mark <= PULSE_MARK_RST;
      cfg_r.space_one  <= SPACE_ONE_RST;
      cfg_r.space_zero <= SPACE_ZERO_RST;
      cfg_r.gap_space  <= GAP_SPACE_RST;
      cfg_r.temp_floor <= TEMP_FLOOR_RST;
      cfg_r.temp_ceil  <= TEMP_CEIL_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_LEAD_MARK:  cfg_r.lead_mark  <= cfg_wdata;
        REG_LEAD_SPACE: cfg_r.lead_space <= cfg_wdata;
        REG_PULSE_MARK: cfg_r.pulse_mark <= cfg_wdata;
        REG_SPACE_ONE:  cfg_r.space_one  <= cfg_wdata;
        REG_SPACE_ZERO: cfg_r.space_zero <= cfg_wdata;
        REG_GAP_SPACE:  cfg_r.gap_space  <= cfg_wdata;
        REG_TEMP_FLOOR: cfg_r.temp_floor <= cfg_wdata[7:0];
        REG_TEMP_CEIL:  cfg_r.temp_ceil  <= cfg_wdata[7:0];
        default:        cfg_r.lead_mark  <= cfg_r.lead_mark;
      endcase
    end
  end

  // an item is taken whenever the output buffer has room
  assign take = in_ch.valid && in_ch.ready;

  acire_seq #(
    .FRAME_BYTES   (FRAME_BYTES),
    .FRAME_REPEATS (FRAME_REPEATS)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (in_ch.data),
    .cfg   (cfg_r),
    .res   (res)
  );

  acire_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_ch.valid),
    .push_ready (in_ch.ready),
    .push_data  (res),
    .pop_valid  (out_ch.valid),
    .pop_ready  (out_ch.ready),
    .pop_data   (out_ch.data)
  );

endmodule
